/* rtl/core/egenc_pkg.sv */
// shared constants, queue entry and status types for the elias gamma encoder
// no dependencies
`timescale 1ns / 1ps

package egenc_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int CODE_BITS   = 2 * VALUE_BITS;
    localparam int CODE_BYTES  = (CODE_BITS + 7) / 8;
    localparam int LEN_W       = $clog2(VALUE_BITS);
    localparam int SH_W        = LEN_W + 1;
    localparam int IDX_W       = $clog2(CODE_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified item waiting for the byte sequencer
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [IDX_W-1:0]     nlast;
        logic                 err;
    } t_code_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef struct packed {
        logic busy;
    } t_back_status;

endpackage

/* rtl/core/egenc_front.sv */
// front end: accepts values, maps them to code numbers and builds the gamma code word
// depends on egenc_pkg
`timescale 1ns / 1ps

module egenc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [egenc_pkg::VALUE_BITS-1:0] i_value,
    input  logic                             i_signed_mode,
    input  egenc_pkg::t_fifo_status          i_fifo_status,
    output logic                             o_push,
    output egenc_pkg::t_code_entry           o_entry
);

    localparam int VB = egenc_pkg::VALUE_BITS;

    logic                            r_v1;
    logic [VB-1:0]                   r_num1;
    logic                            r_err1;
    logic                            r_v2;
    logic [VB-1:0]                   r_num2;
    logic [egenc_pkg::LEN_W-1:0]     r_len2;
    logic                            r_err2;

    logic                            adv1;
    logic                            adv2;
    logic [VB-1:0]                   raw;
    logic                            neg;
    logic [VB-1:0]                   mag;
    logic [VB-1:0]                   n_num;
    logic                            n_err;
    logic [egenc_pkg::LEN_W-1:0]     n_len;
    logic [VB-1:0]                   rev;
    logic [egenc_pkg::SH_W-1:0]      shamt;
    logic [egenc_pkg::CODE_BITS-1:0] code;

    assign adv2    = !r_v2 || !i_fifo_status.full;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    // code number from value and mode
    always_comb begin
        raw = i_value;
        neg = raw[VB-1];
        mag = ~raw + VB'(1);
        n_err = 1'b0;
        if (!i_signed_mode) begin
            n_num = raw + VB'(1);
            n_err = neg;
        end else if (neg) begin
            n_num = {mag[VB-2:0], 1'b0};
            n_err = (raw == {1'b1, {(VB-1){1'b0}}});
        end else begin
            n_num = {raw[VB-2:0], 1'b1};
        end
        if (n_err) begin
            n_num = VB'(1);
        end
    end

    // position of the leading one
    always_comb begin
        n_len = '0;
        for (int i = 0; i < VB; i++) begin
            if (r_num1[i]) begin
                n_len = egenc_pkg::LEN_W'(i);
            end
        end
    end

    // reversed number sits in the top half; one right shift puts bit len at code bit len
    always_comb begin
        for (int i = 0; i < VB; i++) begin
            rev[i] = r_num2[VB-1-i];
        end
        shamt = egenc_pkg::SH_W'(egenc_pkg::CODE_BITS - 1) - {r_len2, 1'b0};
        code  = {rev, {VB{1'b0}}} >> shamt;
    end

    always_comb begin
        o_push        = r_v2 && !i_fifo_status.full;
        o_entry.code  = r_err2 ? '0 : code;
        o_entry.nlast = r_err2 ? '0 : egenc_pkg::IDX_W'(r_len2 >> 2);
        o_entry.err   = r_err2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_num1 <= n_num;
            r_err1 <= n_err;
        end
        if (adv2) begin
            r_num2 <= r_num1;
            r_len2 <= n_len;
            r_err2 <= r_err1;
        end
    end

endmodule

/* rtl/core/egenc_fifo.sv */
// short queue between the front end and the byte sequencer
// depends on egenc_pkg
`timescale 1ns / 1ps

module egenc_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  egenc_pkg::t_code_entry  i_entry,
    input  logic                    i_pop,
    output egenc_pkg::t_code_entry  o_entry,
    output egenc_pkg::t_fifo_status o_status
);

    egenc_pkg::t_code_entry            r_mem [egenc_pkg::QUEUE_DEPTH];
    logic [egenc_pkg::QPTR_W-1:0]      r_wr;
    logic [egenc_pkg::QPTR_W-1:0]      r_rd;
    logic [egenc_pkg::QCNT_W-1:0]      r_cnt;
    logic [egenc_pkg::QCNT_W-1:0]      n_cnt;

    assign o_status.full  = (r_cnt == egenc_pkg::QCNT_W'(egenc_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_entry        = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + egenc_pkg::QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - egenc_pkg::QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == egenc_pkg::QPTR_W'(egenc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : r_wr + egenc_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == egenc_pkg::QPTR_W'(egenc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : r_rd + egenc_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* rtl/core/egenc_back.sv */
// byte sequencer: unloads queued code words one byte per beat into the output register
// depends on egenc_pkg
`timescale 1ns / 1ps

module egenc_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  egenc_pkg::t_code_entry   i_entry,
    input  egenc_pkg::t_fifo_status  i_fifo_status,
    output logic                     o_pop,
    output egenc_pkg::t_back_status  o_status,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [7:0]               o_out_byte,
    output logic                     o_last,
    output logic                     o_error
);

    logic                            r_busy;
    logic [egenc_pkg::CODE_BITS-1:0] r_code;
    logic [egenc_pkg::IDX_W-1:0]     r_idx;
    logic [egenc_pkg::IDX_W-1:0]     r_nlast;
    logic                            r_err;
    logic                            r_ov;
    logic [7:0]                      r_byte;
    logic                            r_last;
    logic                            r_oerr;

    logic                            slot_free;
    logic                            emit;
    logic                            fin;
    logic                            n_busy;

    always_comb begin
        slot_free = !r_ov || !i_stall;
        emit      = r_busy && slot_free;
        fin       = emit && (r_idx == r_nlast);
        o_pop     = !i_fifo_status.empty && (!r_busy || fin);
        n_busy    = o_pop ? 1'b1 : (fin ? 1'b0 : r_busy);
    end

    assign o_status.busy      = r_busy;
    assign o_valid            = r_ov;
    assign o_out_byte         = r_byte;
    assign o_last             = r_last;
    assign o_error            = r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            if (slot_free) begin
                r_ov <= r_busy;
            end
            if (o_pop) begin
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + egenc_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code  <= i_entry.code;
            r_nlast <= i_entry.nlast;
            r_err   <= i_entry.err;
        end else if (emit) begin
            r_code <= r_code >> 8;
        end
        if (emit) begin
            r_byte <= r_code[7:0];
            r_last <= (r_idx == r_nlast);
            r_oerr <= r_err;
        end
    end

endmodule

/* rtl/core/elias_gamma_int_encoder.sv */
// top level of the elias gamma integer encoder: front end, queue, byte sequencer
// depends on egenc_pkg, egenc_front, egenc_fifo, egenc_back
`timescale 1ns / 1ps

// usage
// input channel: i_valid / o_stall carry i_value (signed) and i_signed_mode; a beat is
// taken when i_valid is high and o_stall is low
// output channel: o_valid / i_stall carry o_out_byte, o_last and o_error; each value
// gives floor(L/4)+1 bytes (L = floor(log2 N), so 1 to 8), code bits from bit 0 up,
// o_last on the final byte
// a negative value in unsigned mode, or the most negative value in signed mode, gives
// one byte of zero with o_last and o_error set
// the first byte of a value passes the two front stages, the queue write and the
// sequencer load before it is presented on the output
// throughput: the sequencer sends one byte per cycle while i_stall is low, with no
// gap between queued values; the front end takes a value per cycle until the
// two-entry queue fills
// a stalled output holds its byte; the sequencer and then the front end back up behind
// it and o_stall rises once both front stages and the queue are full
// reset (i_rst_n low at a clock edge) empties the pipeline and the queue; no clearing
// pass follows

module elias_gamma_int_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [egenc_pkg::VALUE_BITS-1:0] i_value,
    input  logic                             i_signed_mode,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last,
    output logic                             o_error
);

    egenc_pkg::t_code_entry  push_entry;
    egenc_pkg::t_code_entry  head_entry;
    egenc_pkg::t_fifo_status fifo_status;
    egenc_pkg::t_back_status back_status;
    logic                    push;
    logic                    pop;

    egenc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_signed_mode (i_signed_mode),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    egenc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (fifo_status)
    );

    egenc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_fifo_status (fifo_status),
        .o_pop         (pop),
        .o_status      (back_status),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_error       (o_error)
    );

    // error results are a single empty byte
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last && (o_out_byte == 8'd0))
        else $error("error beat is not a single zero byte");

    // a waiting queue entry is picked up by an idle sequencer
    a_idle_pickup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fifo_status.empty && !back_status.busy |=> back_status.busy)
        else $error("sequencer left a queued value waiting");

    // bytes of one value follow back to back
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid)
        else $error("gap inside a value's code bytes");

    // nothing is written into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_status.full && !pop |=> $stable(fifo_status.full) && !fifo_status.empty)
        else $error("queue lost its contents while full");

endmodule
